>>> rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/i2cs_pkg.sv
// Types, codes and constants of the I2C transfer sequencer.
package i2cs_pkg;

	localparam int MAX_BYTES_DEF = 16;
	localparam int CNT_W = 5;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	localparam logic [1:0] MODE_W   = 2'd0;
	localparam logic [1:0] MODE_R   = 2'd1;
	localparam logic [1:0] MODE_WR  = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_RSTART = 3'd2,
		CMD_TX     = 3'd3,
		CMD_RCEN   = 3'd4,
		CMD_ACK    = 3'd5,
		CMD_NACK   = 3'd6,
		CMD_STOP   = 3'd7
	} cmd_t;

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_START  = 10'b00_0000_0010,
		PH_ADDR   = 10'b00_0000_0100,
		PH_WDATA  = 10'b00_0000_1000,
		PH_WLAST  = 10'b00_0001_0000,
		PH_RADDR  = 10'b00_0010_0000,
		PH_RACK   = 10'b00_0100_0000,
		PH_RDATA  = 10'b00_1000_0000,
		PH_STOP   = 10'b01_0000_0000,
		PH_FINISH = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       mode;
		logic [7:0]       address;
		logic [7:0]       read_address;
		logic [CNT_W-1:0] write_length;
		logic [CNT_W-1:0] read_length;
		logic [3:0]       write_index;
		logic [7:0]       write_byte;
		logic             ack_status;
		logic [7:0]       bus_rx_byte;
	} req_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] tx_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic [3:0] read_index;
		logic       done_res;
		logic       no_ack_error;
		logic       busy_res;
	} rsp_t;

endpackage

>>> rtl/i2cs_ifs.sv
// Valid/ready channel interfaces for request and response words.
interface i2cs_req_if;
	import i2cs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cs_rsp_if;
	import i2cs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/i2cs_wbuf.sv
// Write data buffer: register file with one write port and one read port.
module i2cs_wbuf #(
	parameter int MAX_BYTES = i2cs_pkg::MAX_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [3:0]                wr_index,
	input  logic [7:0]                wr_data,
	input  logic [i2cs_pkg::CNT_W-1:0] rd_index,
	output logic [7:0]                rd_data
);
	import i2cs_pkg::*;

	// The load index is four bits wide, so no more than sixteen entries are reachable.
	localparam int DEPTH = (MAX_BYTES < 16) ? MAX_BYTES : 16;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] buf_q [DEPTH];
	logic       wr_ok;
	logic       rd_ok;

	assign wr_ok = ({1'b0, wr_index} < 5'(DEPTH));
	assign rd_ok = (rd_index < CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			buf_q[wr_index[AW-1:0]] <= wr_data;
		end
	end

	always_comb begin
		rd_data = 8'd0;
		if (rd_ok) begin
			rd_data = buf_q[rd_index[AW-1:0]];
		end
	end

endmodule

>>> rtl/i2cs_fsm.sv
// Transaction state machine: at most one bus command per word, state advances on step.
module i2cs_fsm #(
	parameter int MAX_BYTES = i2cs_pkg::MAX_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  i2cs_pkg::req_t             req,
	input  logic [7:0]                 buf_data,
	output logic [i2cs_pkg::CNT_W-1:0] buf_index,
	output i2cs_pkg::rsp_t             rsp
);
	import i2cs_pkg::*;

	phase_t           phase_q, phase_d;
	logic [1:0]       mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       addr1_q, addr1_d;
	logic [7:0]       addr2_q, addr2_d;
	logic [CNT_W-1:0] txn_q, txn_d;
	logic [CNT_W-1:0] rxn_q, rxn_d;
	logic             err_q, err_d;
	logic [CNT_W-1:0] cnt_inc;

	function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] len);
		logic [CNT_W-1:0] r;
		r = len;
		if (len == '0) begin
			r = CNT_W'(1);
		end else if ({4'd0, len} > 9'(MAX_BYTES)) begin
			r = CNT_W'(MAX_BYTES);
		end
		return r;
	endfunction

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign buf_index = cnt_q;

	always_comb begin
		phase_d = phase_q;
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		addr1_d = addr1_q;
		addr2_d = addr2_q;
		txn_d   = txn_q;
		rxn_d   = rxn_q;
		err_d   = err_q;
		rsp     = '0;
		rsp.command = CMD_NONE;

		if (req.kind == KIND_START) begin
			if (phase_q == PH_IDLE && req.mode != MODE_BAD) begin
				mode_d  = req.mode;
				addr1_d = req.address;
				addr2_d = req.read_address;
				txn_d   = clamp_len(req.write_length);
				rxn_d   = clamp_len(req.read_length);
				cnt_d   = '0;
				err_d   = 1'b0;
				phase_d = PH_START;
			end
		end else if (req.kind == KIND_EVENT) begin
			unique case (phase_q)
				PH_START: begin
					rsp.command = CMD_START;
					phase_d = PH_ADDR;
				end
				PH_ADDR: begin
					rsp.command = CMD_TX;
					rsp.tx_byte = addr1_q;
					phase_d = (mode_q == MODE_R) ? PH_RACK : PH_WDATA;
				end
				PH_WDATA, PH_WLAST: begin
					if (req.ack_status) begin
						err_d = 1'b1;
						rsp.command = CMD_STOP;
						if (mode_q == MODE_W) begin
							rsp.done_res = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_FINISH;
						end
					end else if (phase_q == PH_WDATA) begin
						rsp.command = CMD_TX;
						rsp.tx_byte = buf_data;
						cnt_d = cnt_inc;
						if (cnt_inc >= txn_q) begin
							phase_d = PH_WLAST;
						end
					end else if (mode_q == MODE_W) begin
						rsp.command = CMD_STOP;
						phase_d = PH_FINISH;
					end else begin
						rsp.command = CMD_RSTART;
						phase_d = PH_RADDR;
					end
				end
				PH_RADDR: begin
					rsp.command = CMD_TX;
					rsp.tx_byte = addr2_q;
					cnt_d = '0;
					phase_d = PH_RACK;
				end
				PH_RACK: begin
					if (req.ack_status) begin
						err_d = 1'b1;
						rsp.command = CMD_STOP;
						phase_d = PH_FINISH;
					end else begin
						rsp.command = CMD_RCEN;
						phase_d = PH_RDATA;
					end
				end
				PH_RDATA: begin
					rsp.read_valid = 1'b1;
					rsp.read_byte  = req.bus_rx_byte;
					rsp.read_index = cnt_q[3:0];
					cnt_d = cnt_inc;
					if (cnt_inc >= rxn_q) begin
						rsp.command = CMD_NACK;
						phase_d = PH_STOP;
					end else begin
						rsp.command = CMD_ACK;
						phase_d = PH_RACK;
					end
				end
				PH_STOP: begin
					rsp.command = CMD_STOP;
					phase_d = PH_FINISH;
				end
				PH_FINISH: begin
					rsp.done_res = 1'b1;
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		rsp.no_ack_error = err_d;
		rsp.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= MODE_W;
			cnt_q   <= '0;
			addr1_q <= 8'd0;
			addr2_q <= 8'd0;
			txn_q   <= CNT_W'(1);
			rxn_q   <= CNT_W'(1);
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			addr1_q <= addr1_d;
			addr2_q <= addr2_d;
			txn_q   <= txn_d;
			rxn_q   <= rxn_d;
			err_q   <= err_d;
		end
	end

endmodule

>>> rtl/i2c_master_transfer_sequencer.sv
// A word accepted into the input register passes through the state machine into the output register.
// Throughput: one word per cycle without back-pressure; the input register advances whenever the
// output register is empty or being taken, so ready only drops under back-pressure.
// Reset clears the phase, counters, address and error state and both valid flags.
// The write buffer is not cleared by reset; its entries hold no value until loaded.
`include "assert_macros.svh"

module i2c_master_transfer_sequencer #(
	parameter int MAX_BYTES = i2cs_pkg::MAX_BYTES_DEF
) (
	input logic            clk,
	input logic            arst_n,
	i2cs_req_if.sink       req,
	i2cs_rsp_if.source     rsp
);
	import i2cs_pkg::*;

	logic             valid_s1;
	req_t             req_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             advance;
	rsp_t             fsm_rsp;
	logic [CNT_W-1:0] buf_index;
	logic [7:0]       buf_data;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	i2cs_wbuf #(.MAX_BYTES(MAX_BYTES)) u_wbuf (
		.clk      (clk),
		.wr_en    (advance && req_s1.kind == KIND_LOAD),
		.wr_index (req_s1.write_index),
		.wr_data  (req_s1.write_byte),
		.rd_index (buf_index),
		.rd_data  (buf_data)
	);

	i2cs_fsm #(.MAX_BYTES(MAX_BYTES)) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.req       (req_s1),
		.buf_data  (buf_data),
		.buf_index (buf_index),
		.rsp       (fsm_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_q <= fsm_rsp;
		end
	end

	`ASSERT_IMPLY(a_rd_cmd, clk, arst_n, rsp_valid_q && rsp_q.read_valid,
		rsp_q.command == CMD_ACK || rsp_q.command == CMD_NACK)
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, rsp_valid_q && rsp_q.done_res, !rsp_q.busy_res)
	`ASSERT_NEXT(a_adv_out, clk, arst_n, advance, rsp_valid_q)
	`ASSERT_IMPLY(a_stall_why, clk, arst_n, valid_s1 && !advance, rsp_valid_q && !rsp.ready)

endmodule
